FILE: rtl/core/lsc_pkg.sv
package lsc_pkg;
  localparam int COORD_BITS = 16;
  localparam int OUT_BITS   = COORD_BITS + 1;
  // working width: differences and moved points stay within COORD_BITS+2
  localparam int WB         = COORD_BITS + 2;
  localparam int PB         = 2 * WB;
  localparam int PCW        = $clog2(PB + 1);

  localparam logic [3:0] CODE_TOP    = 4'd8;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_LEFT   = 4'd1;

  localparam logic [2:0] REG_LEFT   = 3'd0;
  localparam logic [2:0] REG_RIGHT  = 3'd1;
  localparam logic [2:0] REG_BOTTOM = 3'd2;
  localparam logic [2:0] REG_TOP    = 3'd3;
  localparam logic [2:0] REG_SHX    = 3'd4;
  localparam logic [2:0] REG_SHY    = 3'd5;

  localparam int MAX_MOVES = 4;

  typedef logic signed [WB-1:0] wcoord_t;

  function automatic logic [3:0] region(input wcoord_t x, input wcoord_t y,
                                        input wcoord_t l, input wcoord_t r,
                                        input wcoord_t b, input wcoord_t t);
    logic [3:0] c;
    c = 4'd0;
    if (y > t) c = c | CODE_TOP;
    else if (y < b) c = c | CODE_BOTTOM;
    if (x > r) c = c | CODE_RIGHT;
    else if (x < l) c = c | CODE_LEFT;
    return c;
  endfunction
endpackage

FILE: rtl/core/lsc_muldiv.sv
// trunc(a*b/c): bit-serial shift-add multiply, then restoring division one bit a cycle
module lsc_muldiv import lsc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  wcoord_t a,
  input  wcoord_t b,
  input  wcoord_t c,
  output logic    done,
  output wcoord_t q
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]     st_r;
  logic [PCW-1:0] cnt_r;
  logic [PB-1:0]  acc_r;   // product, later shifted out as dividend
  logic [PB-1:0]  mcand_r;
  logic [WB-1:0]  mplr_r;
  logic [WB-1:0]  dvs_r;
  logic [WB:0]    rem_r;
  logic [PB-1:0]  quo_r;
  logic           neg_r;
  logic           zero_r;

  logic [WB-1:0] ua, ub, uc;
  logic [WB:0]   rsh;
  logic [WB:0]   rsub;
  logic [WB-1:0] qn;

  assign ua   = a[WB-1] ? WB'(-a) : WB'(a);
  assign ub   = b[WB-1] ? WB'(-b) : WB'(b);
  assign uc   = c[WB-1] ? WB'(-c) : WB'(c);
  assign rsh  = {rem_r[WB-1:0], acc_r[PB-1]};
  assign rsub = rsh - {1'b0, dvs_r};
  assign qn   = quo_r[WB-1:0];
  assign q    = zero_r ? '0 : (neg_r ? wcoord_t'(-qn) : wcoord_t'(qn));
  assign done = (st_r == S_FIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: if (start) begin
          st_r    <= S_MUL;
          cnt_r   <= PCW'(WB);
          acc_r   <= '0;
          mcand_r <= PB'(ua);
          mplr_r  <= ub;
          dvs_r   <= uc;
          neg_r   <= a[WB-1] ^ b[WB-1] ^ c[WB-1];
          zero_r  <= (uc == '0);
        end
        S_MUL: begin
          if (mplr_r[0]) acc_r <= acc_r + mcand_r;
          mcand_r <= mcand_r << 1;
          mplr_r  <= mplr_r >> 1;
          cnt_r   <= cnt_r - 1'b1;
          if (cnt_r == PCW'(1)) begin
            st_r  <= S_DIV;
            cnt_r <= PCW'(PB);
            rem_r <= '0;
            quo_r <= '0;
          end
        end
        S_DIV: begin
          if (!rsub[WB]) begin
            rem_r <= rsub;
            quo_r <= {quo_r[PB-2:0], 1'b1};
          end else begin
            rem_r <= rsh;
            quo_r <= {quo_r[PB-2:0], 1'b0};
          end
          acc_r <= acc_r << 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == PCW'(1)) st_r <= S_FIN;
        end
        S_FIN: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done held");
  a_div_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> ($past(st_r) == S_MUL || $past(st_r) == S_DIV))
    else $error("bad order");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MUL) && $past(st_r) == S_IDLE |-> $past(start))
    else $error("spurious start");
endmodule

FILE: rtl/core/line_segment_clipper.sv
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | start_x start_y end_x end_y
// out     | out | out_valid/out_ready| accepted clip_start_x/y clip_end_x/y
// cfg     | in  | cfg_we             | cfg_index cfg_data
// One segment at a time; each edge move runs in the serial multiply-divide
// unit (up to four moves). Trivial accept/reject needs no move.
// Reset is synchronous, active low.
// A finished result waits in the output register; the next segment is taken
// once that result register is empty or drained.
module line_segment_clipper import lsc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_accepted,
  output logic signed [OUT_BITS-1:0]   out_clip_start_x,
  output logic signed [OUT_BITS-1:0]   out_clip_start_y,
  output logic signed [OUT_BITS-1:0]   out_clip_end_x,
  output logic signed [OUT_BITS-1:0]   out_clip_end_y,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic signed [COORD_BITS-1:0] wl_r, wr_r, wb_r, wt_r, shx_r, shy_r;
  logic [1:0] st_r;
  wcoord_t x1_r, y1_r, x2_r, y2_r;
  logic [2:0] moves_r;
  logic       acc_r;
  logic       sel1_r, vert_r;
  wcoord_t    edge_r;

  wcoord_t l, r, bw, t;
  logic [3:0] c1, c2, ce;
  logic       md_start, md_done;
  wcoord_t    ma, mb, mc, mq, nv;
  logic       empty_win;

  assign l = wcoord_t'(wl_r);
  assign r = wcoord_t'(wr_r);
  assign bw = wcoord_t'(wb_r);
  assign t = wcoord_t'(wt_r);
  assign c1 = region(x1_r, y1_r, l, r, bw, t);
  assign c2 = region(x2_r, y2_r, l, r, bw, t);
  assign ce = (c1 != 4'd0) ? c1 : c2;
  assign empty_win = (l > r) || (bw > t);

  // operands for the current move; vert means a top/bottom edge
  always_comb begin
    if (vert_r) begin
      ma = wcoord_t'(x2_r - x1_r);
      mb = wcoord_t'(edge_r - y1_r);
      mc = wcoord_t'(y2_r - y1_r);
    end else begin
      ma = wcoord_t'(y2_r - y1_r);
      mb = wcoord_t'(edge_r - x1_r);
      mc = wcoord_t'(x2_r - x1_r);
    end
  end
  assign nv = wcoord_t'((vert_r ? x1_r : y1_r) + mq);

  logic md_go_r;
  assign md_start = md_go_r;

  lsc_muldiv u_md (
    .clk(clk), .rst_n(rst_n), .start(md_start),
    .a(ma), .b(mb), .c(mc), .done(md_done), .q(mq)
  );

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r  <= '0;
      wr_r  <= {1'b0, {(COORD_BITS-1){1'b1}}};
      wb_r  <= '0;
      wt_r  <= {1'b0, {(COORD_BITS-1){1'b1}}};
      shx_r <= '0;
      shy_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT:   wl_r  <= cfg_data;
        REG_RIGHT:  wr_r  <= cfg_data;
        REG_BOTTOM: wb_r  <= cfg_data;
        REG_TOP:    wt_r  <= cfg_data;
        REG_SHX:    shx_r <= cfg_data;
        REG_SHY:    shy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      md_go_r <= 1'b0;
      moves_r <= '0;
    end else begin
      md_go_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_valid) begin
          x1_r    <= wcoord_t'(in_start_x);
          y1_r    <= wcoord_t'(in_start_y);
          x2_r    <= wcoord_t'(in_end_x);
          y2_r    <= wcoord_t'(in_end_y);
          moves_r <= '0;
          st_r    <= S_EVAL;
        end
        S_EVAL: begin
          if (empty_win) begin
            acc_r <= 1'b0;
            st_r  <= S_DONE;
          end else if (c1 == 4'd0 && c2 == 4'd0) begin
            acc_r <= 1'b1;
            st_r  <= S_DONE;
          end else if ((c1 & c2) != 4'd0 || moves_r == 3'(MAX_MOVES)) begin
            acc_r <= 1'b0;
            st_r  <= S_DONE;
          end else begin
            sel1_r  <= (c1 != 4'd0);
            md_go_r <= 1'b1;
            st_r    <= S_WAIT;
            if ((ce & CODE_TOP) != 4'd0) begin
              vert_r <= 1'b1; edge_r <= t;
            end else if ((ce & CODE_BOTTOM) != 4'd0) begin
              vert_r <= 1'b1; edge_r <= bw;
            end else if ((ce & CODE_RIGHT) != 4'd0) begin
              vert_r <= 1'b0; edge_r <= r;
            end else begin
              vert_r <= 1'b0; edge_r <= l;
            end
          end
        end
        S_WAIT: if (md_done) begin
          // swap in the moved point
          if (sel1_r) begin
            if (vert_r) begin x1_r <= nv; y1_r <= edge_r; end
            else begin y1_r <= nv; x1_r <= edge_r; end
          end else begin
            if (vert_r) begin x2_r <= nv; y2_r <= edge_r; end
            else begin y2_r <= nv; x2_r <= edge_r; end
          end
          moves_r <= moves_r + 1'b1;
          st_r    <= S_EVAL;
        end
        S_DONE: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_accepted     = acc_r;
  assign out_clip_start_x = acc_r ? OUT_BITS'(x1_r + wcoord_t'(shx_r)) : '0;
  assign out_clip_start_y = acc_r ? OUT_BITS'(y1_r + wcoord_t'(shy_r)) : '0;
  assign out_clip_end_x   = acc_r ? OUT_BITS'(x2_r + wcoord_t'(shx_r)) : '0;
  assign out_clip_end_y   = acc_r ? OUT_BITS'(y2_r + wcoord_t'(shy_r)) : '0;

  a_moves_cap: assert property (@(posedge clk) disable iff (!rst_n)
    moves_r <= 3'(MAX_MOVES)) else $error("too many moves");
  a_accept_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> (c1 == 4'd0 && c2 == 4'd0))
    else $error("accepted outside window");
  a_wait_started: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WAIT) && $past(st_r) == S_EVAL |-> md_go_r)
    else $error("move without unit start");
endmodule
